### rtl/ibr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibr_pkg
// Shared widths, payload types, register codes and helpers for the IMU
// bias and mounting rotation block.
// ----------------------------------------------------------------------------
package ibr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int QUAT_BITS      = 16;
    localparam int LANE_BITS      = 16;
    localparam int CFG_W          = 64;

    localparam int BIAS_SUM_W = ((SAMPLE_BITS > LANE_BITS) ? SAMPLE_BITS : LANE_BITS) + 1;
    localparam int QPROD_W    = 2 * QUAT_BITS;
    localparam int QACC_W     = QPROD_W + 3;
    localparam int MPROD_W    = 2 * LANE_BITS;
    localparam int ENT_W      = ((MPROD_W + 3) > (2 * QUAT_FRAC_BITS + 2)) ?
                                (MPROD_W + 3) : (2 * QUAT_FRAC_BITS + 2);
    localparam int COEF_W     = ENT_W - QUAT_FRAC_BITS;
    localparam int VPROD_W    = COEF_W + SAMPLE_BITS;
    localparam int VACC_W     = VPROD_W + 3;

    localparam logic [CFG_W-1:0] MOUNT_RESET = 64'd16384;

    typedef enum logic [1:0] {
        CFG_BIAS_ENABLE = 2'd0,
        CFG_MOUNT_QUAT  = 2'd1,
        CFG_GYRO_BIAS   = 2'd2,
        CFG_ACCEL_BIAS  = 2'd3
    } t_cfg_idx;

    // index 0 = x ... 3 = w
    typedef logic [3:0][QUAT_BITS-1:0]   t_quat;
    typedef logic [2:0][SAMPLE_BITS-1:0] t_vec;
    typedef logic [2:0][COEF_W-1:0]      t_row;
    typedef t_row [2:0]                  t_rot;

    typedef struct packed {
        logic signed [QUAT_BITS-1:0]   quat_x;
        logic signed [QUAT_BITS-1:0]   quat_y;
        logic signed [QUAT_BITS-1:0]   quat_z;
        logic signed [QUAT_BITS-1:0]   quat_w;
        logic signed [SAMPLE_BITS-1:0] gyro_x;
        logic signed [SAMPLE_BITS-1:0] gyro_y;
        logic signed [SAMPLE_BITS-1:0] gyro_z;
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
    } t_sample;

    typedef struct packed {
        logic signed [QUAT_BITS-1:0]   out_quat_x;
        logic signed [QUAT_BITS-1:0]   out_quat_y;
        logic signed [QUAT_BITS-1:0]   out_quat_z;
        logic signed [QUAT_BITS-1:0]   out_quat_w;
        logic signed [SAMPLE_BITS-1:0] out_gyro_x;
        logic signed [SAMPLE_BITS-1:0] out_gyro_y;
        logic signed [SAMPLE_BITS-1:0] out_gyro_z;
        logic signed [SAMPLE_BITS-1:0] out_accel_x;
        logic signed [SAMPLE_BITS-1:0] out_accel_y;
        logic signed [SAMPLE_BITS-1:0] out_accel_z;
    } t_result;

    // Mount component feeding each Hamilton product term; terms are ordered
    // qw, qx, qy, qz and packed term 0 in the low bits.
    function automatic logic [7:0] f_qmap(input logic [1:0] lane);
        logic [7:0] map;
        case (lane)
            2'd0:    map = {2'd1, 2'd2, 2'd3, 2'd0};
            2'd1:    map = {2'd0, 2'd3, 2'd2, 2'd1};
            2'd2:    map = {2'd3, 2'd0, 2'd1, 2'd2};
            default: map = {2'd2, 2'd1, 2'd0, 2'd3};
        endcase
        return map;
    endfunction

    // Terms that are subtracted in each Hamilton product lane
    function automatic logic [3:0] f_qneg(input logic [1:0] lane);
        logic [3:0] neg;
        case (lane)
            2'd0:    neg = 4'b1000;
            2'd1:    neg = 4'b0010;
            2'd2:    neg = 4'b0100;
            default: neg = 4'b1110;
        endcase
        return neg;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] f_bias_sat(
        input logic [SAMPLE_BITS-1:0] s,
        input logic [LANE_BITS-1:0]   b
    );
        logic signed [BIAS_SUM_W-1:0]     sum;
        logic [BIAS_SUM_W-SAMPLE_BITS:0]  hi;
        logic [SAMPLE_BITS-1:0]           res;
        sum = BIAS_SUM_W'($signed(s)) + BIAS_SUM_W'($signed(b));
        hi  = sum[BIAS_SUM_W-1:SAMPLE_BITS-1];
        if ((&hi) || !(|hi)) begin
            res = sum[SAMPLE_BITS-1:0];
        end else begin
            res = {sum[BIAS_SUM_W-1], {(SAMPLE_BITS-1){~sum[BIAS_SUM_W-1]}}};
        end
        return res;
    endfunction

endpackage

### rtl/ibr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibr_in_if
// Sample channel: valid/ready handshake carrying one IMU sample.
// ----------------------------------------------------------------------------
interface ibr_in_if
    import ibr_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ibr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibr_out_if
// Result channel: valid/ready handshake carrying one corrected sample.
// ----------------------------------------------------------------------------
interface ibr_out_if
    import ibr_pkg::*;
();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ibr_quat_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibr_quat_lane
// One component of the quaternion product: four registered products, then
// signed sum, round half up and saturate to Q1.14.
// ----------------------------------------------------------------------------
module ibr_quat_lane
    import ibr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  t_quat                i_q,
    input  t_quat                i_m,
    input  logic [3:0]           i_neg,
    output logic [QUAT_BITS-1:0] o_res
);

    localparam logic signed [QACC_W-1:0] HALF =
        {{(QACC_W-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

    logic signed [QPROD_W-1:0]       r_prod [4];
    logic signed [QACC_W-1:0]        acc;
    logic signed [QACC_W-1:0]        term;
    logic signed [QACC_W-1:0]        sh;
    logic [QACC_W-QUAT_BITS:0]       hi;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_prod[i] <= $signed(i_q[i]) * $signed(i_m[i]);
            end
        end
    end

    always_comb begin
        acc = HALF;
        for (int i = 0; i < 4; i++) begin
            term = QACC_W'(r_prod[i]);
            acc  = i_neg[i] ? (acc - term) : (acc + term);
        end
        sh = acc >>> QUAT_FRAC_BITS;
        hi = sh[QACC_W-1:QUAT_BITS-1];
        if ((&hi) || !(|hi)) begin
            o_res = sh[QUAT_BITS-1:0];
        end else begin
            o_res = {sh[QACC_W-1], {(QUAT_BITS-1){~sh[QACC_W-1]}}};
        end
    end

endmodule

### rtl/ibr_vec_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibr_vec_lane
// One output axis of a vector rotation: three registered products of a
// matrix row and the sample, then sum, round half up and saturate.
// ----------------------------------------------------------------------------
module ibr_vec_lane
    import ibr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  t_row                   i_row,
    input  t_vec                   i_vec,
    output logic [SAMPLE_BITS-1:0] o_res
);

    localparam logic signed [VACC_W-1:0] HALF =
        {{(VACC_W-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

    logic signed [VPROD_W-1:0]       r_prod [3];
    logic signed [VACC_W-1:0]        acc;
    logic signed [VACC_W-1:0]        sh;
    logic [VACC_W-SAMPLE_BITS:0]     hi;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= $signed(i_row[i]) * $signed(i_vec[i]);
            end
        end
    end

    always_comb begin
        acc = HALF;
        for (int i = 0; i < 3; i++) begin
            acc = acc + VACC_W'(r_prod[i]);
        end
        sh = acc >>> QUAT_FRAC_BITS;
        hi = sh[VACC_W-1:SAMPLE_BITS-1];
        if ((&hi) || !(|hi)) begin
            o_res = sh[SAMPLE_BITS-1:0];
        end else begin
            o_res = {sh[VACC_W-1], {(SAMPLE_BITS-1){~sh[VACC_W-1]}}};
        end
    end

endmodule

### rtl/ibr_rot_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibr_rot_matrix
// Rotation matrix of the conjugate mounting quaternion, rebuilt every cycle
// from the mount register: registered products, then rounded entries.
// ----------------------------------------------------------------------------
module ibr_rot_matrix
    import ibr_pkg::*;
(
    input  logic  i_clk,
    input  t_quat i_mount,
    output t_rot  o_rot
);

    localparam logic signed [ENT_W-1:0] ONE_E =
        {{(ENT_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);
    localparam logic signed [ENT_W-1:0] HALF_E =
        {{(ENT_W-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

    logic signed [LANE_BITS-1:0] mx, my, mz, mw;
    logic signed [MPROD_W-1:0]   r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_rot                        n_rot;
    t_rot                        r_rot;

    function automatic logic signed [ENT_W-1:0] f_ext(input logic signed [MPROD_W-1:0] v);
        return ENT_W'(v);
    endfunction

    function automatic logic [COEF_W-1:0] f_rnd(input logic signed [ENT_W-1:0] v);
        logic signed [ENT_W-1:0] t;
        t = (v + HALF_E) >>> QUAT_FRAC_BITS;
        return t[COEF_W-1:0];
    endfunction

    assign mx = $signed(i_mount[0]);
    assign my = $signed(i_mount[1]);
    assign mz = $signed(i_mount[2]);
    assign mw = $signed(i_mount[3]);

    always_ff @(posedge i_clk) begin
        r_xx <= mx * mx;
        r_yy <= my * my;
        r_zz <= mz * mz;
        r_xy <= mx * my;
        r_xz <= mx * mz;
        r_yz <= my * mz;
        r_wx <= mw * mx;
        r_wy <= mw * my;
        r_wz <= mw * mz;
        r_rot <= n_rot;
    end

    always_comb begin
        n_rot[0][0] = f_rnd(ONE_E - ((f_ext(r_yy) + f_ext(r_zz)) <<< 1));
        n_rot[0][1] = f_rnd((f_ext(r_xy) + f_ext(r_wz)) <<< 1);
        n_rot[0][2] = f_rnd((f_ext(r_xz) - f_ext(r_wy)) <<< 1);
        n_rot[1][0] = f_rnd((f_ext(r_xy) - f_ext(r_wz)) <<< 1);
        n_rot[1][1] = f_rnd(ONE_E - ((f_ext(r_xx) + f_ext(r_zz)) <<< 1));
        n_rot[1][2] = f_rnd((f_ext(r_yz) + f_ext(r_wx)) <<< 1);
        n_rot[2][0] = f_rnd((f_ext(r_xz) + f_ext(r_wy)) <<< 1);
        n_rot[2][1] = f_rnd((f_ext(r_yz) - f_ext(r_wx)) <<< 1);
        n_rot[2][2] = f_rnd(ONE_E - ((f_ext(r_xx) + f_ext(r_yy)) <<< 1));
    end

    assign o_rot = r_rot;

endmodule

### rtl/imu_bias_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_rotation
// Throughput: one sample per cycle while the output takes results; four
// pipeline stages each advance when the stage after them is empty or moving,
// so ready drops only when all hold. Mount writes reach the rotation matrix
// registers through the product registers.
// Reset clears the stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module imu_bias_rotation
    import ibr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    ibr_in_if.sink           i_in,
    ibr_out_if.source        o_out
);

    logic                   r_bias_en;
    logic [CFG_W-1:0]       r_mount;
    logic [3*LANE_BITS-1:0] r_gyro_bias;
    logic [3*LANE_BITS-1:0] r_accel_bias;

    logic  r_v0, r_v1, r_v2, r_v3;
    logic  en0, en1, en2, en3;
    logic  in_xfer, out_xfer;

    t_quat r_q0, r_q1, r_q2;
    t_vec  r_g0, r_g1, r_g2;
    t_vec  r_a0, r_a1, r_a2;
    t_quat n_q0;
    t_vec  n_g0, n_a0, n_g1, n_a1;
    t_quat mount_q;
    t_quat q_terms;
    t_rot  rot;
    t_quat q_res;
    t_vec  g_res, a_res;
    t_result n_out;
    t_result r_out;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_en    <= 1'b0;
            r_mount      <= MOUNT_RESET;
            r_gyro_bias  <= '0;
            r_accel_bias <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIAS_ENABLE: r_bias_en    <= i_cfg_data[0];
                CFG_MOUNT_QUAT:  r_mount      <= i_cfg_data;
                CFG_GYRO_BIAS:   r_gyro_bias  <= i_cfg_data[3*LANE_BITS-1:0];
                CFG_ACCEL_BIAS:  r_accel_bias <= i_cfg_data[3*LANE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------
    assign en3      = !r_v3 || o_out.ready;
    assign en2      = !r_v2 || en3;
    assign en1      = !r_v1 || en2;
    assign en0      = !r_v0 || en1;
    assign i_in.ready = en0 && i_rst_n;
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_v3 && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_in.valid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: capture, stage 1: bias add
    // ------------------------------------------------------------------
    assign n_q0 = {i_in.data.quat_w, i_in.data.quat_z, i_in.data.quat_y, i_in.data.quat_x};
    assign n_g0 = {i_in.data.gyro_z, i_in.data.gyro_y, i_in.data.gyro_x};
    assign n_a0 = {i_in.data.accel_z, i_in.data.accel_y, i_in.data.accel_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_g1[i] = r_bias_en ? f_bias_sat(r_g0[i], r_gyro_bias[i*LANE_BITS +: LANE_BITS])
                                : r_g0[i];
            n_a1[i] = r_bias_en ? f_bias_sat(r_a0[i], r_accel_bias[i*LANE_BITS +: LANE_BITS])
                                : r_a0[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_q0 <= n_q0;
            r_g0 <= n_g0;
            r_a0 <= n_a0;
        end
        if (en1) begin
            r_q1 <= r_q0;
            r_g1 <= n_g1;
            r_a1 <= n_a1;
        end
        if (en2) begin
            r_q2 <= r_q1;
            r_g2 <= r_g1;
            r_a2 <= r_a1;
        end
    end

    // ------------------------------------------------------------------
    // Lanes: stage 2 products, finished at the output register
    // ------------------------------------------------------------------
    assign mount_q    = r_mount[4*LANE_BITS-1:0];
    assign q_terms[0] = r_q1[3];
    assign q_terms[1] = r_q1[0];
    assign q_terms[2] = r_q1[1];
    assign q_terms[3] = r_q1[2];

    ibr_rot_matrix u_rot (
        .i_clk   (i_clk),
        .i_mount (mount_q),
        .o_rot   (rot)
    );

    for (genvar k = 0; k < 4; k++) begin : g_quat
        localparam logic [7:0] MAP = f_qmap(2'(k));
        t_quat m_terms;

        for (genvar t = 0; t < 4; t++) begin : g_term
            assign m_terms[t] = mount_q[MAP[2*t +: 2]];
        end

        ibr_quat_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en2),
            .i_q   (q_terms),
            .i_m   (m_terms),
            .i_neg (f_qneg(2'(k))),
            .o_res (q_res[k])
        );
    end

    for (genvar r = 0; r < 3; r++) begin : g_vec
        ibr_vec_lane u_gyro (
            .i_clk (i_clk),
            .i_en  (en2),
            .i_row (rot[r]),
            .i_vec (r_g1),
            .o_res (g_res[r])
        );

        ibr_vec_lane u_accel (
            .i_clk (i_clk),
            .i_en  (en2),
            .i_row (rot[r]),
            .i_vec (r_a1),
            .o_res (a_res[r])
        );
    end

    // ------------------------------------------------------------------
    // Merge lanes, or the stage 2 sample when disabled, into the output register
    // ------------------------------------------------------------------
    always_comb begin
        if (r_bias_en) begin
            n_out.out_quat_x  = q_res[0];
            n_out.out_quat_y  = q_res[1];
            n_out.out_quat_z  = q_res[2];
            n_out.out_quat_w  = q_res[3];
            n_out.out_gyro_x  = g_res[0];
            n_out.out_gyro_y  = g_res[1];
            n_out.out_gyro_z  = g_res[2];
            n_out.out_accel_x = a_res[0];
            n_out.out_accel_y = a_res[1];
            n_out.out_accel_z = a_res[2];
        end else begin
            n_out.out_quat_x  = r_q2[0];
            n_out.out_quat_y  = r_q2[1];
            n_out.out_quat_z  = r_q2[2];
            n_out.out_quat_w  = r_q2[3];
            n_out.out_gyro_x  = r_g2[0];
            n_out.out_gyro_y  = r_g2[1];
            n_out.out_gyro_z  = r_g2[2];
            n_out.out_accel_x = r_a2[0];
            n_out.out_accel_y = r_a2[1];
            n_out.out_accel_z = r_a2[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_v3;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_v0, r_v1, r_v2, r_v3}) ==
            $past($countones({r_v0, r_v1, r_v2, r_v3})) + $past(32'(in_xfer))
            - $past(32'(out_xfer)))
        else $error("pipeline occupancy does not track transfers");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_v0 && r_v1 && r_v2 && r_v3))
        else $error("input stalled while a stage is empty");

    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_v0)
        else $error("accepted sample not held in stage 0");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for imu_bias_rotation. A predictor computes the bias
// add, quaternion product and vector rotation for every transferred sample (or passes it
// through while disabled), and the monitor checks each output transfer field by field
// against the oldest prediction. Registers are reprogrammed between drained phases:
// directed extremes first, then random samples under random and extreme mount
// quaternions and biases, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb;
    import ibr_pkg::*;

    localparam int LAT        = 3;
    localparam int CYCLE_CAP  = 300000;
    localparam int RAND_ITEMS = 150;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic             cfg_we   = 1'b0;
    t_cfg_idx         cfg_idx  = CFG_BIAS_ENABLE;
    logic [CFG_W-1:0] cfg_data = '0;

    logic    in_valid  = 1'b0;
    t_sample in_data   = '0;
    logic    res_ready = 1'b0;

    ibr_in_if  in_if ();
    ibr_out_if out_if ();

    assign in_if.valid  = in_valid;
    assign in_if.data   = in_data;
    assign out_if.ready = res_ready;

    imu_bias_rotation u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // register shadow used by the predictor
    logic        bias_on   = 1'b0;
    logic [63:0] mount_q   = 64'd16384;
    logic [47:0] gyro_ofs  = '0;
    logic [47:0] accel_ofs = '0;

    t_sample sample_q[$];
    t_result corrected_q[$];

    int fail_count = 0;
    int cycle_cnt  = 0;
    int burst_left = 0;
    int gap_left   = 0;
    int stall_tick = 0;
    int stall_mode = 0;

    string field_name[10] = '{"accel_z", "accel_y", "accel_x", "gyro_z", "gyro_y",
                              "gyro_x", "quat_w", "quat_z", "quat_y", "quat_x"};

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint sat16(longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    function automatic longint rnd_frac(longint x);
        return (x + (longint'(1) <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
    endfunction

    function automatic t_result correct_sample(t_sample s);
        longint  q[4];
        longint  g[3];
        longint  a[3];
        longint  m[4];
        longint  p[4];
        longint  e[3][3];
        longint  r[3][3];
        longint  og[3];
        longint  oa[3];
        longint  one;
        t_result res;
        if (!bias_on) return t_result'(s);
        q[0] = $signed(s.quat_x);
        q[1] = $signed(s.quat_y);
        q[2] = $signed(s.quat_z);
        q[3] = $signed(s.quat_w);
        g[0] = $signed(s.gyro_x);
        g[1] = $signed(s.gyro_y);
        g[2] = $signed(s.gyro_z);
        a[0] = $signed(s.accel_x);
        a[1] = $signed(s.accel_y);
        a[2] = $signed(s.accel_z);
        for (int i = 0; i < 4; i++) m[i] = $signed(mount_q[16*i +: 16]);
        for (int i = 0; i < 3; i++) begin
            g[i] = sat16(g[i] + longint'($signed(gyro_ofs[16*i +: 16])));
            a[i] = sat16(a[i] + longint'($signed(accel_ofs[16*i +: 16])));
        end
        // Hamilton product q * m
        p[0] = q[3]*m[0] + q[0]*m[3] + q[1]*m[2] - q[2]*m[1];
        p[1] = q[3]*m[1] - q[0]*m[2] + q[1]*m[3] + q[2]*m[0];
        p[2] = q[3]*m[2] + q[0]*m[1] - q[1]*m[0] + q[2]*m[3];
        p[3] = q[3]*m[3] - q[0]*m[0] - q[1]*m[1] - q[2]*m[2];
        // rotation matrix of conj(m) at scale 2^(2F)
        one = longint'(1) <<< (2 * QUAT_FRAC_BITS);
        e[0][0] = one - 2 * (m[1]*m[1] + m[2]*m[2]);
        e[0][1] = 2 * (m[0]*m[1] + m[3]*m[2]);
        e[0][2] = 2 * (m[0]*m[2] - m[3]*m[1]);
        e[1][0] = 2 * (m[0]*m[1] - m[3]*m[2]);
        e[1][1] = one - 2 * (m[0]*m[0] + m[2]*m[2]);
        e[1][2] = 2 * (m[1]*m[2] + m[3]*m[0]);
        e[2][0] = 2 * (m[0]*m[2] + m[3]*m[1]);
        e[2][1] = 2 * (m[1]*m[2] - m[3]*m[0]);
        e[2][2] = one - 2 * (m[0]*m[0] + m[1]*m[1]);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) r[i][j] = rnd_frac(e[i][j]);
        end
        for (int i = 0; i < 3; i++) begin
            og[i] = sat16(rnd_frac(r[i][0]*g[0] + r[i][1]*g[1] + r[i][2]*g[2]));
            oa[i] = sat16(rnd_frac(r[i][0]*a[0] + r[i][1]*a[1] + r[i][2]*a[2]));
        end
        res.out_quat_x  = 16'(sat16(rnd_frac(p[0])));
        res.out_quat_y  = 16'(sat16(rnd_frac(p[1])));
        res.out_quat_z  = 16'(sat16(rnd_frac(p[2])));
        res.out_quat_w  = 16'(sat16(rnd_frac(p[3])));
        res.out_gyro_x  = 16'(og[0]);
        res.out_gyro_y  = 16'(og[1]);
        res.out_gyro_z  = 16'(og[2]);
        res.out_accel_x = 16'(oa[0]);
        res.out_accel_y = 16'(oa[1]);
        res.out_accel_z = 16'(oa[2]);
        return res;
    endfunction

    task automatic report(string msg);
        if (fail_count < 40) $display("%0t mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic t_sample uniform_sample(logic [15:0] v);
        return t_sample'({10{v}});
    endfunction

    function automatic logic [15:0] rand_lane();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_sample rand_sample();
        logic [9:0][15:0] w;
        for (int i = 0; i < 10; i++) w[i] = rand_lane();
        return t_sample'(w);
    endfunction

    function automatic logic [63:0] rand_mount(int kind);
        logic [63:0] v;
        for (int i = 0; i < 4; i++) begin
            if (kind == 0) v[16*i +: 16] = 16'($urandom_range(0, 32768) - 16384);
            else           v[16*i +: 16] = rand_lane();
        end
        return v;
    endfunction

    function automatic logic [47:0] rand_bias(int kind);
        logic [47:0] v;
        for (int i = 0; i < 3; i++) begin
            if (kind == 0) v[16*i +: 16] = 16'($urandom_range(0, 512) - 256);
            else           v[16*i +: 16] = rand_lane();
        end
        return v;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_BIAS_ENABLE: bias_on   = val[0];
            CFG_MOUNT_QUAT:  mount_q   = val;
            CFG_GYRO_BIAS:   gyro_ofs  = val[47:0];
            CFG_ACCEL_BIAS:  accel_ofs = val[47:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(logic en, logic [63:0] mq, logic [47:0] gb, logic [47:0] ab);
        write_reg(CFG_MOUNT_QUAT, mq);
        write_reg(CFG_GYRO_BIAS, {16'h0, gb});
        write_reg(CFG_ACCEL_BIAS, {16'h0, ab});
        write_reg(CFG_BIAS_ENABLE, {63'h0, en});
        // let the mount write settle into the rotation matrix
        repeat (LAT) @(posedge i_clk);
    endtask

    // hold until every expected result has come back
    task automatic drain();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || in_valid || corrected_q.size() != 0);
        repeat (LAT + 2) @(posedge i_clk);
    endtask

    task automatic push_extremes();
        sample_q.push_back(uniform_sample(16'h7FFF));
        sample_q.push_back(uniform_sample(16'h8000));
        sample_q.push_back(uniform_sample(16'h0000));
        sample_q.push_back(t_sample'({{4{16'h7FFF}}, {6{16'h8000}}}));
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_if.ready) corrected_q.push_back(correct_sample(in_data));
            if (!in_valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    in_data  <= sample_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern in randomly chosen modes; check transfers
    always @(posedge i_clk) begin
        logic [9:0][15:0] got_w;
        logic [9:0][15:0] exp_w;
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (out_if.valid && res_ready) begin
                if (corrected_q.size() == 0) begin
                    report("result transfer with no sample outstanding");
                end else begin
                    got_w = out_if.data;
                    exp_w = corrected_q.pop_front();
                    for (int i = 0; i < 10; i++) begin
                        if (got_w[i] !== exp_w[i])
                            report($sformatf("%s got %h exp %h", field_name[i],
                                             got_w[i], exp_w[i]));
                    end
                end
            end
            stall_tick++;
            if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       res_ready <= 1'b1;
                1:       res_ready <= 1'($urandom_range(0, 1));
                2:       res_ready <= (stall_tick % 3 == 0);
                default: res_ready <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset defaults: disabled, samples pass through
        push_extremes();
        sample_q.push_back(uniform_sample(16'h5555));
        sample_q.push_back(uniform_sample(16'hAAAA));
        drain();

        // enabled with the reset mount quaternion
        write_reg(CFG_BIAS_ENABLE, 64'd1);
        repeat (LAT) @(posedge i_clk);
        push_extremes();
        drain();

        // non-unit extreme mounts with saturating biases
        program_regs(1'b1, {4{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}});
        push_extremes();
        drain();
        program_regs(1'b1, {4{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}});
        push_extremes();
        drain();

        // identity mount
        program_regs(1'b1, {16'h4000, 48'h0}, 48'h0, 48'h0);
        sample_q.push_back(uniform_sample(16'h4000));
        sample_q.push_back(rand_sample());
        sample_q.push_back(rand_sample());
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: program_regs(1'b0, rand_mount(1), rand_bias(1), rand_bias(1));
                1: program_regs(1'b1, rand_mount(0), rand_bias(0), rand_bias(0));
                2: program_regs(1'b1, rand_mount(1), rand_bias(1), rand_bias(1));
                3: program_regs(1'b1, {4{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
                4: program_regs(1'b1, {4{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
                5: program_regs(1'b1, {16'h4000, 48'h0}, rand_bias(1), rand_bias(0));
                default: program_regs(1'b1, rand_mount(0), rand_bias(1), rand_bias(1));
            endcase
            for (int n = 0; n < RAND_ITEMS; n++) sample_q.push_back(rand_sample());
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
